FILE: design/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the footswitch press classifier
// Holds the event codes, the configuration register indexes, the layout of
// the configuration registers and the per-switch classifier state.
// ----------------------------------------------------------------------------
package fpc_pkg;

  // Number of footswitches and the width of a switch index.
  localparam int NUM_SWITCHES = 2;
  localparam int SW_IDX_W     = $clog2(NUM_SWITCHES);

  // Field widths.
  localparam int TIME_W   = 32;
  localparam int WINDOW_W = 16;
  localparam int COUNT_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // The press counter stops at this value.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;
  // A count at or above this value gives a double press.
  localparam logic [COUNT_W-1:0] COUNT_DOUBLE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLASSIFIER_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_ENABLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_ENABLE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME         = 3'd5;

  // Reset values of the timing registers.
  localparam logic [WINDOW_W-1:0] DOUBLE_WINDOW_RST = 16'd300;
  localparam logic [WINDOW_W-1:0] HOLD_TIME_RST     = 16'd2000;

  // Event codes reported on the result channel.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_NORMAL = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } press_event_t;

  // Configuration registers.
  typedef struct packed {
    logic                classifier_enable;
    logic                normal_event_enable;
    logic                double_event_enable;
    logic                long_event_enable;
    logic [WINDOW_W-1:0] double_window_ms;
    logic [WINDOW_W-1:0] hold_time_ms;
  } cfg_t;

  // State kept for one footswitch.
  typedef struct packed {
    logic               prev_edge;
    logic [TIME_W-1:0]  press_start_time;
    logic [TIME_W-1:0]  last_press_time;
    logic [COUNT_W-1:0] press_count;
    logic               long_fired;
  } sw_state_t;

  // One service call as held in the input register.
  typedef struct packed {
    logic [SW_IDX_W-1:0] switch_index;
    logic [TIME_W-1:0]   now_ms;
    logic                press_edge;
    logic                held_level;
    logic                both_physical_held;
  } call_t;

endpackage

FILE: design/fpc_state.sv
// ----------------------------------------------------------------------------
// fpc_state: per-switch state registers
// Holds the press tracking state of every footswitch, read at the switch
// being serviced and written back when its call moves to the result stage.
// ----------------------------------------------------------------------------
module fpc_state (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fpc_pkg::SW_IDX_W-1:0]     rd_sel,
  output fpc_pkg::sw_state_t               rd_state,
  input  logic                             wr_en,
  input  logic [fpc_pkg::SW_IDX_W-1:0]     wr_sel,
  input  fpc_pkg::sw_state_t               wr_state
);

  fpc_pkg::sw_state_t state_r [fpc_pkg::NUM_SWITCHES];

  // State update; reset clears every switch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < fpc_pkg::NUM_SWITCHES; s++) begin
        state_r[s] <= '0;
      end
    end else if (wr_en) begin
      state_r[wr_sel] <= wr_state;
    end
  end

  // Read port for the switch in the input register.
  assign rd_state = state_r[rd_sel];

endmodule

FILE: design/fpc_core.sv
// ----------------------------------------------------------------------------
// fpc_core: press classification logic
// Given one service call and the state of its switch, works out the event
// and the switch's next state in a single combinational pass.
// ----------------------------------------------------------------------------
module fpc_core (
  input  fpc_pkg::cfg_t         cfg,
  input  fpc_pkg::call_t        call,
  input  fpc_pkg::sw_state_t    cur,
  output fpc_pkg::sw_state_t    nxt,
  output fpc_pkg::press_event_t press_event
);

  logic                          pressed;
  logic                          released;
  logic [fpc_pkg::TIME_W-1:0]    since_last;
  logic [fpc_pkg::TIME_W-1:0]    dur;
  logic                          in_window;
  logic                          hold_reached;
  fpc_pkg::sw_state_t            st;
  fpc_pkg::press_event_t         ev;

  // A press begins when the edge flag rises between two calls; it ends on
  // the first call after that with the flag clear.
  assign pressed  = call.press_edge && !cur.prev_edge;
  assign released = !call.press_edge && cur.prev_edge;

  // Time differences wrap modulo 2^32. A fresh press restarts the hold time.
  assign since_last   = call.now_ms - cur.last_press_time;
  assign in_window    = since_last <= {{(fpc_pkg::TIME_W-fpc_pkg::WINDOW_W){1'b0}},
                                       cfg.double_window_ms};
  assign dur          = pressed ? '0 : (call.now_ms - cur.press_start_time);
  assign hold_reached = dur >= {{(fpc_pkg::TIME_W-fpc_pkg::WINDOW_W){1'b0}},
                                cfg.hold_time_ms};

  // Classification, in the order press start, long hold, release.
  always_comb begin
    st = cur;
    ev = fpc_pkg::EV_NONE;

    if (pressed) begin
      st.press_start_time = call.now_ms;
      if (in_window) begin
        if (cur.press_count != fpc_pkg::COUNT_MAX) begin
          st.press_count = cur.press_count + 2'd1;
        end
      end else begin
        st.press_count = 2'd1;
      end
      st.last_press_time = call.now_ms;
      st.long_fired      = 1'b0;
    end

    // Long press fires once per press; suppressed while both are held.
    if (call.held_level && hold_reached && !st.long_fired) begin
      if (!call.both_physical_held && cfg.long_event_enable) begin
        ev = fpc_pkg::EV_LONG;
      end
      st.long_fired = 1'b1;
    end

    // Release of a press that did not fire a long event.
    if (released && !st.long_fired) begin
      if (st.press_count >= fpc_pkg::COUNT_DOUBLE) begin
        if (cfg.double_event_enable) begin
          ev = fpc_pkg::EV_DOUBLE;
        end
        st.press_count = '0;
      end else if (!hold_reached && cfg.normal_event_enable) begin
        ev = fpc_pkg::EV_NORMAL;
      end
    end

    st.prev_edge = call.press_edge;

    // A disabled classifier leaves the state alone and reports nothing.
    if (!cfg.classifier_enable) begin
      nxt         = cur;
      press_event = fpc_pkg::EV_NONE;
    end else begin
      nxt         = st;
      press_event = ev;
    end
  end

endmodule

FILE: design/footswitch_press_classifier.sv
// ----------------------------------------------------------------------------
// footswitch_press_classifier: two-switch press event classifier
// Turns service calls of two footswitches into normal, double and long
// press events.
//
//   Port group | Direction | Handshake        | Contents
//   in_        | input     | in_valid/stall   | switch, time, edge, held, both
//   out_       | output    | out_valid/stall  | press_event, one per call
//   cfg_       | input     | cfg_we           | register index and data
//
// A call lands in the input register at its input transfer; the classification
// pass then moves it into the result register, from which it transfers out.
// One item is accepted every cycle while the output does not stall; the
// per-switch state is written back as the item enters the result register,
// so the next call sees it at once. A stall on the output holds the result
// register and then the input register, after which in_stall rises. Reset is
// synchronous; it clears both stages and all switch state, and loads the
// configuration registers with their reset values.
// ----------------------------------------------------------------------------
module footswitch_press_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fpc_pkg::SW_IDX_W-1:0]       in_switch_index,
  input  logic [fpc_pkg::TIME_W-1:0]         in_now_ms,
  input  logic                               in_press_edge,
  input  logic                               in_held_level,
  input  logic                               in_both_physical_held,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_press_event,
  // Configuration port
  input  logic                               cfg_we,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  fpc_pkg::cfg_t          cfg_r;
  fpc_pkg::call_t         s1_call_r;
  logic                   s1_vld_r;
  logic                   out_vld_r;
  fpc_pkg::press_event_t  out_event_r;
  logic                   out_free;
  logic                   s1_adv;
  logic                   in_xfer;
  fpc_pkg::sw_state_t     cur_state;
  fpc_pkg::sw_state_t     nxt_state;
  fpc_pkg::press_event_t  event_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.classifier_enable   <= 1'b0;
      cfg_r.normal_event_enable <= 1'b1;
      cfg_r.double_event_enable <= 1'b1;
      cfg_r.long_event_enable   <= 1'b1;
      cfg_r.double_window_ms    <= fpc_pkg::DOUBLE_WINDOW_RST;
      cfg_r.hold_time_ms        <= fpc_pkg::HOLD_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fpc_pkg::CFG_CLASSIFIER_ENABLE: cfg_r.classifier_enable   <= cfg_wdata[0];
        fpc_pkg::CFG_NORMAL_ENABLE:     cfg_r.normal_event_enable <= cfg_wdata[0];
        fpc_pkg::CFG_DOUBLE_ENABLE:     cfg_r.double_event_enable <= cfg_wdata[0];
        fpc_pkg::CFG_LONG_ENABLE:       cfg_r.long_event_enable   <= cfg_wdata[0];
        fpc_pkg::CFG_DOUBLE_WINDOW:     cfg_r.double_window_ms    <= cfg_wdata;
        fpc_pkg::CFG_HOLD_TIME:         cfg_r.hold_time_ms        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the result register takes a new item when empty or drained,
  // and the input register is free when empty or moving on.
  assign out_free = !out_vld_r || !out_stall;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_xfer) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_call_r.switch_index       <= in_switch_index;
      s1_call_r.now_ms             <= in_now_ms;
      s1_call_r.press_edge         <= in_press_edge;
      s1_call_r.held_level         <= in_held_level;
      s1_call_r.both_physical_held <= in_both_physical_held;
    end
  end

  // Per-switch state, updated as the call leaves the input register.
  fpc_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_sel   (s1_call_r.switch_index),
    .rd_state (cur_state),
    .wr_en    (s1_adv),
    .wr_sel   (s1_call_r.switch_index),
    .wr_state (nxt_state)
  );

  // Classification pass.
  fpc_core u_core (
    .cfg         (cfg_r),
    .call        (s1_call_r),
    .cur         (cur_state),
    .nxt         (nxt_state),
    .press_event (event_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event_r <= event_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_press_event = out_event_r;

`ifndef NO_ASSERTIONS
  // A call that moves on always lands in the result register.
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("advancing call did not reach the result register");

  // A call held back by a stall is never dropped.
  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_adv |=> s1_vld_r)
    else $error("stalled call lost from the input register");

  // The input side stalls only with a call waiting in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a blocked call");

  // A disabled classifier reports no event.
  a_disabled_none: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !cfg_r.classifier_enable |=> out_event_r == fpc_pkg::EV_NONE)
    else $error("event reported while the classifier is disabled");
`endif

endmodule
